// ----- design/hrcp_pkg.sv -----
// Package for the HTTP response chunked parser: phases, result kinds, flags and tag tables.
// No dependencies; hrcp_core, hrcp_out_queue and the top level refer to it by scoped names.
`default_nettype none
package hrcp_pkg;

  localparam int MaxLineDefault = 4096;

  typedef enum logic [2:0] {
    PH_STATUS = 3'd0,
    PH_HEADER = 3'd1,
    PH_BODY   = 3'd2,
    PH_CSIZE  = 3'd3,
    PH_CDATA  = 3'd4,
    PH_CTRAIL = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BODY   = 2'd0,
    KIND_STATUS = 2'd1,
    KIND_DONE   = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  // Per-line flag bits.
  localparam int HmA     = 0;
  localparam int HmB     = 1;
  localparam int HmColon = 2;
  localparam int HmStart = 3;
  localparam int HmStop  = 4;

  localparam logic [31:0] Sat32 = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  body_byte;
    logic [9:0]  status_code;
    logic        version_minor;
    logic [31:0] body_total;
    logic        last;
  } result_t;

  // Up to two results per input byte.
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } result_pair_t;

  function automatic logic [7:0] lower(input logic [7:0] b);
    lower = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    is_space = (b == 8'h20) || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic [7:0] tag_http(input logic [2:0] i);
    case (i)
      3'd0: tag_http = "h";
      3'd1: tag_http = "t";
      3'd2: tag_http = "t";
      3'd3: tag_http = "p";
      3'd4: tag_http = "/";
      3'd5: tag_http = "1";
      3'd6: tag_http = ".";
      default: tag_http = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] tag_te(input logic [4:0] i);
    case (i)
      5'd0: tag_te = "t";   5'd1: tag_te = "r";   5'd2: tag_te = "a";
      5'd3: tag_te = "n";   5'd4: tag_te = "s";   5'd5: tag_te = "f";
      5'd6: tag_te = "e";   5'd7: tag_te = "r";   5'd8: tag_te = "-";
      5'd9: tag_te = "e";   5'd10: tag_te = "n";  5'd11: tag_te = "c";
      5'd12: tag_te = "o";  5'd13: tag_te = "d";  5'd14: tag_te = "i";
      5'd15: tag_te = "n";  5'd16: tag_te = "g";
      default: tag_te = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] tag_cl(input logic [3:0] i);
    case (i)
      4'd0: tag_cl = "c";   4'd1: tag_cl = "o";   4'd2: tag_cl = "n";
      4'd3: tag_cl = "t";   4'd4: tag_cl = "e";   4'd5: tag_cl = "n";
      4'd6: tag_cl = "t";   4'd7: tag_cl = "-";   4'd8: tag_cl = "l";
      4'd9: tag_cl = "e";   4'd10: tag_cl = "n"; 4'd11: tag_cl = "g";
      4'd12: tag_cl = "t";  4'd13: tag_cl = "h";
      default: tag_cl = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] tag_chunked(input logic [2:0] i);
    case (i)
      3'd0: tag_chunked = "c";
      3'd1: tag_chunked = "h";
      3'd2: tag_chunked = "u";
      3'd3: tag_chunked = "n";
      3'd4: tag_chunked = "k";
      3'd5: tag_chunked = "e";
      3'd6: tag_chunked = "d";
      default: tag_chunked = 8'h00;
    endcase
  endfunction

endpackage
`default_nettype wire

// ----- design/hrcp_byte_if.sv -----
// Valid/ready channel carrying one input byte of the response stream.
// No dependencies.
`default_nettype none
interface hrcp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface
`default_nettype wire

// ----- design/hrcp_result_if.sv -----
// Valid/ready channel carrying one parse result.
// No dependencies.
`default_nettype none
interface hrcp_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  body_byte;
  logic [9:0]  status_code;
  logic        version_minor;
  logic [31:0] body_total;
  logic        last;
  modport source (output valid, output kind, output body_byte, output status_code,
                  output version_minor, output body_total, output last, input ready);
  modport sink   (input valid, input kind, input body_byte, input status_code,
                  input version_minor, input body_total, input last, output ready);
endinterface
`default_nettype wire

// ----- design/hrcp_core.sv -----
// Parser state and per-byte next-state logic; yields up to two results per byte.
// Depends on hrcp_pkg.
`default_nettype none
module hrcp_core #(
  parameter int MAX_LINE = hrcp_pkg::MaxLineDefault
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  step,
  input  wire logic [7:0]            in_byte,
  output hrcp_pkg::result_pair_t     res
);
  localparam int OffW = $clog2(MAX_LINE);
  localparam logic [OffW-1:0] OffLimit = OffW'(MAX_LINE - 2);

  hrcp_pkg::phase_t phase, phase_next;
  logic [OffW-1:0] line_offset, line_offset_next;
  logic cr_pending, cr_pending_next;
  logic [4:0] header_match, header_match_next;
  logic [9:0] code_accum, code_accum_next;
  logic version_bit, version_bit_next;
  logic chunked_flag, chunked_flag_next;
  logic [31:0] length_accum, length_accum_next;
  logic [31:0] bytes_left, bytes_left_next;
  logic last_chunk_zero, last_chunk_zero_next;
  logic [1:0] trailer_count, trailer_count_next;
  logic [31:0] delivered_count, delivered_count_next;

  // Digit value of a byte, 16 when not a hex digit.
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [7:0] l;
    l = hrcp_pkg::lower(b);
    if (b >= "0" && b <= "9") hex_val = 5'(b - "0");
    else if (l >= "a" && l <= "f") hex_val = 5'(l - "a" + 8'd10);
    else hex_val = 5'd16;
  endfunction

  // Saturating decimal step for the status code (limit 999).
  function automatic logic [9:0] dec10(input logic [9:0] acc, input logic [3:0] d);
    logic [13:0] t;
    t = 14'(acc) * 14'd10 + 14'(d);
    dec10 = (t > 14'd999) ? 10'd999 : t[9:0];
  endfunction

  function automatic logic [31:0] dec32(input logic [31:0] acc, input logic [3:0] d);
    logic [36:0] t;
    t = {acc, 3'b000} + {2'b00, acc, 1'b0} + 37'(d);
    dec32 = (t[36:32] != 5'd0) ? hrcp_pkg::Sat32 : t[31:0];
  endfunction

  function automatic logic [31:0] hex32(input logic [31:0] acc, input logic [3:0] d);
    hex32 = (acc[31:28] != 4'd0) ? hrcp_pkg::Sat32 : {acc[27:0], d};
  endfunction

  // Effect of one content byte on a line; two content bytes may occur (CR + other).
  typedef struct packed {
    logic [OffW-1:0] off;
    logic [4:0]      hm;
    logic [9:0]      code;
    logic            ver;
    logic [31:0]     len;
    logic            ok;
  } lstate_t;

  function automatic lstate_t line_byte(input lstate_t s, input hrcp_pkg::phase_t ph,
                                        input logic [7:0] b);
    lstate_t n;
    logic [4:0] d;
    logic [7:0] l;
    logic te, cl;
    logic [9:0] vi, k;
    logic num_ok;
    n = s;
    d = hex_val(b);
    l = hrcp_pkg::lower(b);
    te = 1'b0;
    cl = 1'b0;
    vi = 10'd0;
    k = 10'd0;
    num_ok = 1'b0;
    if (s.off >= OffLimit) begin
      n.ok = 1'b0;
    end else begin
      n.ok = 1'b1;
      n.off = s.off + 1'b1;
      // A number digit is used only while not stopped and past leading blanks.
      num_ok = !s.hm[hrcp_pkg::HmStop] &&
               !(!s.hm[hrcp_pkg::HmStart] && hrcp_pkg::is_space(b));
      case (ph)
        hrcp_pkg::PH_STATUS: begin
          if (s.off < OffW'(7)) begin
            if (l != hrcp_pkg::tag_http(s.off[2:0])) n.hm[hrcp_pkg::HmA] = 1'b1;
          end else if (s.off == OffW'(7)) begin
            if (b == "1") n.ver = 1'b1;
            else if (b == "0") n.ver = 1'b0;
            else n.hm[hrcp_pkg::HmA] = 1'b1;
          end else if (s.off >= OffW'(9) && num_ok) begin
            if (d >= 5'd10) n.hm[hrcp_pkg::HmStop] = 1'b1;
            else begin
              n.hm[hrcp_pkg::HmStart] = 1'b1;
              n.code = dec10(s.code, d[3:0]);
            end
          end
        end
        hrcp_pkg::PH_HEADER: begin
          if (!s.hm[hrcp_pkg::HmColon]) begin
            if (b == ":") begin
              te = s.hm[hrcp_pkg::HmA] && s.off == OffW'(17);
              cl = s.hm[hrcp_pkg::HmB] && s.off == OffW'(14);
              n.hm = 5'd0;
              n.hm[hrcp_pkg::HmColon] = 1'b1;
              n.hm[hrcp_pkg::HmA] = te;
              n.hm[hrcp_pkg::HmB] = cl;
              n.code = 10'd0;
              if (cl) n.len = 32'd0;
            end else begin
              if (!(s.off < OffW'(17) && l == hrcp_pkg::tag_te(s.off[4:0])))
                n.hm[hrcp_pkg::HmA] = 1'b0;
              if (!(s.off < OffW'(14) && l == hrcp_pkg::tag_cl(s.off[3:0])))
                n.hm[hrcp_pkg::HmB] = 1'b0;
            end
          end else begin
            vi = s.code;
            if (s.code < 10'd1023) n.code = s.code + 10'd1;
            if (s.hm[hrcp_pkg::HmA]) begin
              if (vi == 10'd0 && b == " ") begin
                n.hm[hrcp_pkg::HmStart] = 1'b1;
              end else begin
                k = vi - {9'd0, s.hm[hrcp_pkg::HmStart]};
                if (k >= 10'd7 || l != hrcp_pkg::tag_chunked(k[2:0]))
                  n.hm[hrcp_pkg::HmStop] = 1'b1;
              end
            end else if (s.hm[hrcp_pkg::HmB] && num_ok) begin
              if (d >= 5'd10) n.hm[hrcp_pkg::HmStop] = 1'b1;
              else begin
                n.hm[hrcp_pkg::HmStart] = 1'b1;
                n.len = dec32(s.len, d[3:0]);
              end
            end
          end
        end
        hrcp_pkg::PH_CSIZE: begin
          if (num_ok) begin
            if (d >= 5'd16) n.hm[hrcp_pkg::HmStop] = 1'b1;
            else begin
              n.hm[hrcp_pkg::HmStart] = 1'b1;
              n.len = hex32(s.len, d[3:0]);
            end
          end
        end
        default: ;
      endcase
    end
    return n;
  endfunction

  lstate_t ls0, ls1, ls2;
  hrcp_pkg::result_t r_a, r_b;
  logic [1:0] n_res;
  logic do_clear;
  logic [31:0] bl_dec, dc_inc;

  always_comb begin
    phase_next = phase;
    line_offset_next = line_offset;
    cr_pending_next = cr_pending;
    header_match_next = header_match;
    code_accum_next = code_accum;
    version_bit_next = version_bit;
    chunked_flag_next = chunked_flag;
    length_accum_next = length_accum;
    bytes_left_next = bytes_left;
    last_chunk_zero_next = last_chunk_zero;
    trailer_count_next = trailer_count;
    delivered_count_next = delivered_count;
    r_a = '0;
    r_b = '0;
    n_res = 2'd0;
    do_clear = 1'b0;
    ls0 = '{off: line_offset, hm: header_match, code: code_accum, ver: version_bit,
            len: length_accum, ok: 1'b1};
    ls1 = ls0;
    ls2 = ls0;
    bl_dec = (bytes_left != 32'd0) ? bytes_left - 32'd1 : 32'd0;
    dc_inc = (delivered_count != hrcp_pkg::Sat32) ? delivered_count + 32'd1
                                                  : delivered_count;

    case (phase)
      hrcp_pkg::PH_BODY, hrcp_pkg::PH_CDATA: begin
        r_a.kind = hrcp_pkg::KIND_BODY;
        r_a.body_byte = in_byte;
        n_res = 2'd1;
        delivered_count_next = dc_inc;
        bytes_left_next = bl_dec;
        if (bl_dec == 32'd0) begin
          if (phase == hrcp_pkg::PH_BODY) begin
            r_b.kind = hrcp_pkg::KIND_DONE;
            r_b.body_total = dc_inc;
            n_res = 2'd2;
            do_clear = 1'b1;
          end else begin
            phase_next = hrcp_pkg::PH_CTRAIL;
            trailer_count_next = 2'd0;
            last_chunk_zero_next = 1'b0;
          end
        end
      end
      hrcp_pkg::PH_CTRAIL: begin
        trailer_count_next = trailer_count + 2'd1;
        if (trailer_count != 2'd0) begin
          trailer_count_next = 2'd0;
          if (last_chunk_zero) begin
            r_a.kind = hrcp_pkg::KIND_DONE;
            r_a.body_total = delivered_count;
            n_res = 2'd1;
            do_clear = 1'b1;
          end else begin
            phase_next = hrcp_pkg::PH_CSIZE;
            length_accum_next = 32'd0;
            line_offset_next = '0;
            cr_pending_next = 1'b0;
            header_match_next = 5'd0;
          end
        end
      end
      hrcp_pkg::PH_STATUS, hrcp_pkg::PH_HEADER, hrcp_pkg::PH_CSIZE: begin
        if (cr_pending && in_byte == 8'h0A) begin
          cr_pending_next = 1'b0;
          // Line end.
          if (phase == hrcp_pkg::PH_STATUS) begin
            if (header_match[hrcp_pkg::HmA] || line_offset < OffW'(8)) begin
              r_a.kind = hrcp_pkg::KIND_ERROR;
              n_res = 2'd1;
              do_clear = 1'b1;
            end else begin
              r_a.kind = hrcp_pkg::KIND_STATUS;
              r_a.status_code = code_accum;
              r_a.version_minor = version_bit;
              n_res = 2'd1;
              phase_next = hrcp_pkg::PH_HEADER;
              line_offset_next = '0;
              header_match_next = 5'b00011;
            end
          end else if (phase == hrcp_pkg::PH_HEADER) begin
            if (line_offset == '0) begin
              if (chunked_flag) begin
                phase_next = hrcp_pkg::PH_CSIZE;
                length_accum_next = 32'd0;
                line_offset_next = '0;
                header_match_next = 5'd0;
              end else if (length_accum != 32'd0) begin
                phase_next = hrcp_pkg::PH_BODY;
                bytes_left_next = length_accum;
              end else begin
                r_a.kind = hrcp_pkg::KIND_DONE;
                r_a.body_total = delivered_count;
                n_res = 2'd1;
                do_clear = 1'b1;
              end
            end else if (!header_match[hrcp_pkg::HmColon]) begin
              r_a.kind = hrcp_pkg::KIND_ERROR;
              n_res = 2'd1;
              do_clear = 1'b1;
            end else begin
              if (header_match[hrcp_pkg::HmA])
                chunked_flag_next = !header_match[hrcp_pkg::HmStop] &&
                  (code_accum - {9'd0, header_match[hrcp_pkg::HmStart]} == 10'd7);
              line_offset_next = '0;
              header_match_next = 5'b00011;
            end
          end else begin
            length_accum_next = 32'd0;
            if (length_accum != 32'd0) begin
              bytes_left_next = length_accum;
              phase_next = hrcp_pkg::PH_CDATA;
            end else begin
              last_chunk_zero_next = 1'b1;
              trailer_count_next = 2'd0;
              phase_next = hrcp_pkg::PH_CTRAIL;
            end
          end
        end else if (!cr_pending && in_byte == 8'h0D) begin
          cr_pending_next = 1'b1;
        end else begin
          cr_pending_next = 1'b0;
          if (cr_pending) begin
            ls1 = line_byte(ls0, phase, 8'h0D);
            ls2 = ls1.ok ? line_byte(ls1, phase, in_byte) : ls1;
          end else begin
            ls2 = line_byte(ls0, phase, in_byte);
            ls1 = ls2;
          end
          if (!ls1.ok || !ls2.ok) begin
            r_a.kind = hrcp_pkg::KIND_ERROR;
            n_res = 2'd1;
            do_clear = 1'b1;
          end else begin
            line_offset_next = ls2.off;
            header_match_next = ls2.hm;
            code_accum_next = ls2.code;
            version_bit_next = ls2.ver;
            length_accum_next = ls2.len;
          end
        end
      end
      default: do_clear = 1'b1;
    endcase

    if (n_res == 2'd2) r_b.last = 1'b1;
    else r_a.last = 1'b1;
    res.count = n_res;
    res.r0 = r_a;
    res.r1 = r_b;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && do_clear)) begin
      phase <= hrcp_pkg::PH_STATUS;
      line_offset <= '0;
      cr_pending <= 1'b0;
      header_match <= 5'd0;
      code_accum <= 10'd0;
      version_bit <= 1'b0;
      chunked_flag <= 1'b0;
      length_accum <= 32'd0;
      bytes_left <= 32'd0;
      last_chunk_zero <= 1'b0;
      trailer_count <= 2'd0;
      delivered_count <= 32'd0;
    end else if (step) begin
      phase <= phase_next;
      line_offset <= line_offset_next;
      cr_pending <= cr_pending_next;
      header_match <= header_match_next;
      code_accum <= code_accum_next;
      version_bit <= version_bit_next;
      chunked_flag <= chunked_flag_next;
      length_accum <= length_accum_next;
      bytes_left <= bytes_left_next;
      last_chunk_zero <= last_chunk_zero_next;
      trailer_count <= trailer_count_next;
      delivered_count <= delivered_count_next;
    end
  end

`ifndef SYNTHESIS
  a_offset_bound: assert property (@(posedge clk) disable iff (rst)
    line_offset <= OffLimit)
    else $error("line offset beyond limit");
  a_body_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == hrcp_pkg::PH_BODY || phase == hrcp_pkg::PH_CDATA) |-> bytes_left != 32'd0)
    else $error("body phase with no bytes left");
  a_cr_text: assert property (@(posedge clk) disable iff (rst)
    cr_pending |-> (phase == hrcp_pkg::PH_STATUS || phase == hrcp_pkg::PH_HEADER ||
                    phase == hrcp_pkg::PH_CSIZE))
    else $error("CR pending outside a line phase");
`endif
endmodule
`default_nettype wire

// ----- design/hrcp_out_queue.sv -----
// Output queue of four results that decouples the parser from the result sink.
// Depends on hrcp_pkg.
`default_nettype none
module hrcp_out_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  hrcp_pkg::result_pair_t     pair,
  output logic                       room,
  output logic                       valid,
  input  wire logic                  ready,
  output hrcp_pkg::result_t          head
);
  hrcp_pkg::result_t mem [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] fill, fill_next;
  logic pop;
  logic [1:0] n_push;

  assign pop = valid && ready;
  assign n_push = push ? pair.count : 2'd0;
  assign valid = fill != 3'd0;
  assign head = mem[rd_ptr];
  // Room for two more after any pop this cycle.
  assign room = (fill - {2'b00, pop}) <= 3'd2;
  assign fill_next = fill + {1'b0, n_push} - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      fill <= 3'd0;
    end else begin
      if (n_push != 2'd0) mem[wr_ptr] <= pair.r0;
      if (n_push == 2'd2) mem[wr_ptr + 2'd1] <= pair.r1;
      wr_ptr <= wr_ptr + n_push;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      fill <= fill_next;
    end
  end

`ifndef SYNTHESIS
  a_no_over: assert property (@(posedge clk) disable iff (rst) fill <= 3'd4)
    else $error("queue overflow");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push && pair.count != 2'd0) |-> room)
    else $error("push without room");
  a_fill_track: assert property (@(posedge clk) disable iff (rst)
    (!push && !pop) |=> $stable(fill))
    else $error("fill changed with no traffic");
`endif
endmodule
`default_nettype wire

// ----- design/http_response_chunked_parser.sv -----
// Top level of the HTTP/1.x response parser with chunked decoding.
// Depends on hrcp_pkg, hrcp_byte_if, hrcp_result_if, hrcp_core and hrcp_out_queue.
`default_nettype none
// The parser takes one response byte per cycle and emits body bytes and the
// events status, complete and error on the result channel, each result marked
// last when it is the final one caused by its byte. Every byte is handled
// combinationally: the parser state registers feed short compare and accumulate
// logic whose results go into a four-entry output queue. A byte is accepted
// whenever the queue has room for two results after any pop in the same cycle,
// so with a result sink that is always ready the sustained rate is one byte per
// cycle with no stall at all. The last body byte of a Content-Length body yields
// two results, but with such a sink the queue then holds at most two entries,
// which still leaves room for the next byte. Input stalls come only from a
// result sink that holds off. Each result is registered in the output queue
// before it reaches the result channel. After completion or an error the parser
// returns to its reset state and the next byte starts a new status line.
module http_response_chunked_parser #(
  parameter int MAX_LINE = hrcp_pkg::MaxLineDefault
) (
  input wire logic       clk,
  input wire logic       rst,
  hrcp_byte_if.sink      in_ch,
  hrcp_result_if.source  out_ch
);
  hrcp_pkg::result_pair_t pair;
  hrcp_pkg::result_t head;
  logic room, step;

  assign in_ch.ready = room;
  assign step = in_ch.valid && room;

  hrcp_core #(.MAX_LINE(MAX_LINE)) u_core (
    .clk(clk), .rst(rst), .step(step), .in_byte(in_ch.in_byte), .res(pair)
  );

  hrcp_out_queue u_queue (
    .clk(clk), .rst(rst), .push(step), .pair(pair), .room(room),
    .valid(out_ch.valid), .ready(out_ch.ready), .head(head)
  );

  assign out_ch.kind = head.kind;
  assign out_ch.body_byte = head.body_byte;
  assign out_ch.status_code = head.status_code;
  assign out_ch.version_minor = head.version_minor;
  assign out_ch.body_total = head.body_total;
  assign out_ch.last = head.last;
endmodule
`default_nettype wire
